// ===== sv/crw_pkg.sv =====
// ----------------------------------------------------------------------------
// crw_pkg
// Shared types and codes for the code range width table.
// ----------------------------------------------------------------------------
package crw_pkg;

	localparam int TABLE_DEPTH_DEF   = 256;
	localparam logic [15:0] DEFAULT_WIDTH_RST = 16'd1000;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] last;
		logic [15:0] width;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] width;
	} res_t;

endpackage

// ===== sv/code_range_width_table.sv =====
// ----------------------------------------------------------------------------
// code_range_width_table
// Range table with width per range, cached binary search or newest-first scan.
// Add, clear and cache hit give a result straight from the idle state.
// Sorted lookup: binary search, one table read per search step.
// Unsorted lookup: one entry per cycle from the table port.
// One item at a time; the next transfer is taken the cycle after the result
// moves into the output register.
// Reset clears count and cache and sets the sorted flag; table entries stay unwritten.
// ----------------------------------------------------------------------------
module code_range_width_table #(
	parameter int TABLE_DEPTH = crw_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [crw_pkg::IN_DATA_W-1:0]  s_tdata,  // first_code, last_code, new_width, lookup_code
	input  logic [1:0]                     s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [crw_pkg::OUT_DATA_W-1:0] m_tdata,  // status[1:0], width_out[17:2]
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [15:0]                    cfg_data
);
	import crw_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_BS   = 5'b00010,
		S_FIN  = 5'b00100,
		S_SCAN = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic          sorted_q, sorted_d, has_prev_q, has_prev_d;
	logic [31:0]   prev_last_q, prev_last_d;
	logic          cache_valid_q, cache_valid_d;
	logic [31:0]   cache_first_q, cache_first_d, cache_last_q, cache_last_d;
	logic [15:0]   cache_width_q, cache_width_d;
	logic [15:0]   default_width_q;
	logic [31:0]   code_q, code_d;
	res_t          res_q, res_d;

	entry_t        table_q [TABLE_DEPTH];
	entry_t        rd_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr;
	entry_t        wr_entry;

	logic [31:0]   in_first, in_last, in_code;
	logic [15:0]   in_width;
	logic          accept, res_ready;
	logic          ge, in_range;
	logic [CW-1:0] lo_n, hi_n, mid_n;

	assign in_first = s_tdata[31:0];
	assign in_last  = s_tdata[63:32];
	assign in_width = s_tdata[79:64];
	assign in_code  = s_tdata[111:80];
	assign wr_entry = '{first: in_first, last: in_last, width: in_width};

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign ge       = (rd_q.first <= code_q);
	assign in_range = (code_q >= rd_q.first) && (code_q <= rd_q.last);
	assign lo_n     = ge ? (mid_q + CW'(1)) : lo_q;
	assign hi_n     = ge ? hi_q : mid_q;
	assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		mid_d         = mid_q;
		sorted_d      = sorted_q;
		has_prev_d    = has_prev_q;
		prev_last_d   = prev_last_q;
		cache_valid_d = cache_valid_q;
		cache_first_d = cache_first_q;
		cache_last_d  = cache_last_q;
		cache_width_d = cache_width_q;
		code_d        = code_q;
		res_d         = res_q;
		rd_en         = 1'b0;
		rd_addr       = '0;
		wr_en         = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d   = '{status: ST_OK, width: 16'd0};
					code_d  = in_code;
					state_d = S_DONE;
					case (s_tuser)
						OP_ADD: begin
							if (in_last < in_first) begin
								res_d.status = ST_MALFORMED;
							end else if (count_q >= DEPTH_C) begin
								res_d.status = ST_FULL;
							end else begin
								wr_en = 1'b1;
								if (has_prev_q && in_first <= prev_last_q) begin
									sorted_d = 1'b0;
								end
								count_d     = count_q + CW'(1);
								prev_last_d = in_last;
								has_prev_d  = 1'b1;
							end
						end
						OP_LOOKUP: begin
							if (cache_valid_q && in_code >= cache_first_q
								&& in_code <= cache_last_q) begin
								res_d.width = cache_width_q;
							end else if (count_q == '0) begin
								res_d.width = default_width_q;
							end else if (sorted_q) begin
								lo_d    = '0;
								hi_d    = count_q;
								mid_d   = count_q >> 1;
								rd_en   = 1'b1;
								rd_addr = mid_d[AW-1:0];
								state_d = S_BS;
							end else begin
								mid_d   = count_q - CW'(1);
								rd_en   = 1'b1;
								rd_addr = mid_d[AW-1:0];
								state_d = S_SCAN;
							end
						end
						OP_CLEAR: begin
							count_d       = '0;
							sorted_d      = 1'b1;
							has_prev_d    = 1'b0;
							prev_last_d   = '0;
							cache_valid_d = 1'b0;
							cache_first_d = '0;
							cache_last_d  = '0;
							cache_width_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_BS: begin
				lo_d = lo_n;
				hi_d = hi_n;
				if (lo_n < hi_n) begin
					mid_d   = mid_n;
					rd_en   = 1'b1;
					rd_addr = mid_n[AW-1:0];
				end else if (lo_n == '0) begin
					res_d.width = default_width_q;
					state_d     = S_DONE;
				end else begin
					mid_d   = lo_n - CW'(1);
					rd_en   = 1'b1;
					rd_addr = mid_d[AW-1:0];
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_DONE;
				if (code_q <= rd_q.last) begin
					cache_valid_d = 1'b1;
					cache_first_d = rd_q.first;
					cache_last_d  = rd_q.last;
					cache_width_d = rd_q.width;
					res_d.width   = rd_q.width;
				end else begin
					res_d.width = default_width_q;
				end
			end
			S_SCAN: begin
				if (in_range) begin
					cache_valid_d = 1'b1;
					cache_first_d = rd_q.first;
					cache_last_d  = rd_q.last;
					cache_width_d = rd_q.width;
					res_d.width   = rd_q.width;
					state_d       = S_DONE;
				end else if (mid_q == '0) begin
					res_d.width = default_width_q;
					state_d     = S_DONE;
				end else begin
					mid_d   = mid_q - CW'(1);
					rd_en   = 1'b1;
					rd_addr = mid_d[AW-1:0];
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			sorted_q        <= 1'b1;
			has_prev_q      <= 1'b0;
			prev_last_q     <= '0;
			cache_valid_q   <= 1'b0;
			cache_first_q   <= '0;
			cache_last_q    <= '0;
			cache_width_q   <= '0;
			default_width_q <= DEFAULT_WIDTH_RST;
		end else begin
			state_q       <= state_d;
			count_q       <= count_d;
			sorted_q      <= sorted_d;
			has_prev_q    <= has_prev_d;
			prev_last_q   <= prev_last_d;
			cache_valid_q <= cache_valid_d;
			cache_first_q <= cache_first_d;
			cache_last_q  <= cache_last_d;
			cache_width_q <= cache_width_d;
			if (cfg_valid && cfg_ready) begin
				default_width_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		code_q <= code_d;
		res_q  <= res_d;
	end

	// Items run one at a time, so a write never overlaps a read of the same entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[count_q[AW-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= table_q[rd_addr];
		end
	end

	crw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (state_q == S_DONE),
		.res_ready (res_ready),
		.res       (res_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("transfer taken while an item is in flight");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_BS || state_q == S_FIN) |-> mid_q < count_q)
		else $error("table read beyond filled entries");

	a_width_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17:2] != 16'd0) |-> m_tdata[1:0] == ST_OK)
		else $error("nonzero width with error status");

endmodule

// ===== sv/crw_out_reg.sv =====
// ----------------------------------------------------------------------------
// crw_out_reg
// Result register between the lookup engine and the master stream side.
// ----------------------------------------------------------------------------
module crw_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_valid,
	output logic                           res_ready,
	input  crw_pkg::res_t                  res,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [crw_pkg::OUT_DATA_W-1:0] m_tdata  // status[1:0], width_out[17:2]
);
	import crw_pkg::*;

	logic full_q;
	res_t data_q;

	assign res_ready = !full_q || m_tready;
	assign m_tvalid  = full_q;
	assign m_tdata   = {6'd0, data_q.width, data_q.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res_ready) begin
			full_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

endmodule
